### hdl/acss_pkg.sv
package acss_pkg;

	// Default number of converter channels.
	localparam int CHANNELS_DEF = 16;

	// Width of one converter sample and of one stored reading.
	localparam int SAMPLE_BITS = 10;

	// Fixed field widths of the stream and configuration ports.
	localparam int PIN_W = 8;
	localparam int REF_W = 2;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W = 8;
	localparam int CHAN_OUT_W = 4;
	localparam int MUX_W = 8;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 32;
	localparam int RES_W = 26;

	// Reset values of the configuration registers.
	localparam logic [PIN_W-1:0] PIN_OFFSET_RST = 8'd14;
	localparam logic [REF_W-1:0] REF_SEL_RST = 2'd1;

	// Input beat kinds; code 3 is not used.
	typedef enum logic [KIND_W-1:0] {
		KIND_READ = 2'd0,
		KIND_TICK = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIN_OFFSET       = 1'b0,
		REG_REFERENCE_SELECT = 1'b1
	} cfg_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic read_mem;
		logic commit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// Mux code: reference in bits 7..6, low three channel bits in 2..0.
	function automatic logic [MUX_W-1:0] mux_code(input logic [REF_W-1:0] ref_sel,
			input logic [PIN_W-1:0] chan);
		return {ref_sel, 3'b000, chan[2:0]};
	endfunction

endpackage

### hdl/acss_ctrl.sv
module acss_ctrl
	import acss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Sequence each beat: capture, memory read, then commit once the output is free.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read_mem = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/acss_datapath.sv
module acss_datapath
	import acss_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [KIND_W-1:0]     s_tuser,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam logic [PIN_W-1:0] CHAN_LIMIT = PIN_W'(CHANNELS);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CHANNELS);

	logic [PIN_W-1:0]       pin_offset_q;
	logic [REF_W-1:0]       ref_sel_q;
	kind_t                  kind_q;
	logic [PIN_W-1:0]       pin_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	logic [SAMPLE_BITS-1:0] tbl_mem [CHANNELS];
	logic [CHANNELS-1:0]    tbl_vld_q;
	logic [SAMPLE_BITS-1:0] tbl_rd_q;
	logic                   tbl_vld_rd_q;
	logic [CH_W-1:0]        stk_mem [CHANNELS];
	logic [CH_W-1:0]        stk_rd_q;

	logic [CNT_W-1:0] stack_cnt_q, cnt_d, cnt_dec;
	logic [CH_W-1:0]  act_ch_q, act_ch_d;
	logic             act_vld_q, act_vld_d;
	logic             await_first_q, await_d;

	logic [PIN_W-1:0] chan_full;
	logic             chan_ok;
	logic [CH_W-1:0]  chan_idx, pop_idx;

	logic                   tbl_we, stk_we, do_pop;
	logic [SAMPLE_BITS-1:0] res_reading;
	logic                   res_start, res_dropped, res_bank;
	logic [CH_W-1:0]        emit_ch;
	logic [PIN_W-1:0]       emit_ext;
	logic [CHAN_OUT_W-1:0]  res_chan;
	logic [MUX_W-1:0]       res_mux;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_offset_q <= PIN_OFFSET_RST;
			ref_sel_q <= REF_SEL_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PIN_OFFSET:       pin_offset_q <= cfg_data;
				REG_REFERENCE_SELECT: ref_sel_q <= cfg_data[REF_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the accepted input beat.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= kind_t'(s_tuser);
			pin_q <= s_tdata[PIN_W-1:0];
			sample_q <= s_tdata[PIN_W +: SAMPLE_BITS];
		end
	end

	// Pin to channel mapping and stack addresses.
	assign chan_full = (pin_q >= pin_offset_q) ? (pin_q - pin_offset_q) : pin_q;
	assign chan_ok = (chan_full < CHAN_LIMIT);
	assign chan_idx = chan_full[CH_W-1:0];
	assign cnt_dec = stack_cnt_q - CNT_W'(1);
	assign pop_idx = cnt_dec[CH_W-1:0];

	// Reading table memory.
	always_ff @(posedge clk) begin
		if (cmd.read_mem) begin
			tbl_rd_q <= tbl_mem[chan_idx];
			tbl_vld_rd_q <= tbl_vld_q[chan_idx];
		end
		if (tbl_we && cmd.commit) begin
			tbl_mem[act_ch_q] <= sample_q;
		end
	end

	// A table entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (tbl_we && cmd.commit) begin
			tbl_vld_q[act_ch_q] <= 1'b1;
		end
	end

	// Request stack memory; the read always targets the top entry.
	always_ff @(posedge clk) begin
		if (cmd.read_mem) begin
			stk_rd_q <= stk_mem[pop_idx];
		end
		if (stk_we && cmd.commit) begin
			stk_mem[stack_cnt_q[CH_W-1:0]] <= chan_idx;
		end
	end

	// Decide the state update and the result for the captured beat.
	always_comb begin
		cnt_d = stack_cnt_q;
		act_ch_d = act_ch_q;
		act_vld_d = act_vld_q;
		await_d = await_first_q;
		tbl_we = 1'b0;
		stk_we = 1'b0;
		do_pop = 1'b0;
		res_reading = '0;
		res_start = 1'b0;
		res_dropped = 1'b0;
		emit_ch = act_ch_q;
		case (kind_q)
			KIND_READ: begin
				if (!chan_ok) begin
					res_dropped = 1'b1;
				end else begin
					res_reading = tbl_vld_rd_q ? tbl_rd_q : '0;
					if (stack_cnt_q < CNT_FULL) begin
						stk_we = 1'b1;
						cnt_d = stack_cnt_q + CNT_W'(1);
					end else begin
						res_dropped = 1'b1;
					end
				end
			end
			KIND_TICK: begin
				do_pop = !act_vld_q;
			end
			KIND_DONE: begin
				if (act_vld_q) begin
					if (await_first_q) begin
						res_start = 1'b1;
						await_d = 1'b0;
					end else begin
						tbl_we = 1'b1;
						do_pop = 1'b1;
					end
				end
			end
			default: ;
		endcase
		// Pop the next channel and start it, or fall idle on an empty stack.
		if (do_pop) begin
			await_d = 1'b1;
			if (stack_cnt_q != '0) begin
				cnt_d = cnt_dec;
				act_ch_d = stk_rd_q;
				act_vld_d = 1'b1;
				res_start = 1'b1;
				emit_ch = stk_rd_q;
			end else begin
				cnt_d = '0;
				act_vld_d = 1'b0;
			end
		end
	end

	// Channel fields are zero unless a conversion starts.
	assign emit_ext = {{(PIN_W-CH_W){1'b0}}, emit_ch};
	assign res_chan = res_start ? emit_ext[CHAN_OUT_W-1:0] : '0;
	assign res_mux = res_start ? mux_code(ref_sel_q, emit_ext) : '0;
	assign res_bank = res_start & emit_ext[3];

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_cnt_q <= '0;
			act_ch_q <= '0;
			act_vld_q <= 1'b0;
			await_first_q <= 1'b1;
		end else if (cmd.commit) begin
			stack_cnt_q <= cnt_d;
			act_ch_q <= act_ch_d;
			act_vld_q <= act_vld_d;
			await_first_q <= await_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= {{(OUT_DATA_W-RES_W){1'b0}}, res_dropped, act_vld_d, res_bank,
				res_mux, res_chan, res_start, res_reading};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign stat.out_free = !out_valid_q || m_tready;

endmodule

### hdl/adc_channel_scan_sequencer_unit.sv
// Each input beat passes capture, memory read and commit; the result beat is registered at
// the commit, and a new beat is accepted only after it. The memory read step is set by the
// registered read of the reading table and the request stack; a stalled output delays commit.
// Reset: arst_n clears the sequencer state, the table valid bits and the output valid,
// and loads pin_offset 14 and reference_select 1; no clearing pass is needed.
module adc_channel_scan_sequencer_unit
	import acss_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // pin[7:0], sample[17:8], zero[23:18]
	input  logic [KIND_W-1:0]     s_tuser,  // kind[1:0]
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// reading[9:0], start_conversion[10], conversion_channel[14:11], mux_setting[22:15],
	// channel_bank[23], busy_res[24], request_dropped[25], zero[31:26]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	acss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	acss_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### hdl/acss_checker.sv
module acss_checker
	import acss_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// No result is offered while reset is applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// A stalled result holds its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// One beat at a time: after an accept the input side closes.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// Channel fields are zero unless a conversion starts.
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[10] |-> m_tdata[23:11] == 13'd0)
		else $error("channel fields set without a conversion start");

	// A started conversion leaves the sequencer busy, and a dropped request starts nothing.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> m_tdata[24] && !m_tdata[25])
		else $error("conversion start inconsistent with busy or drop");

endmodule

bind adc_channel_scan_sequencer_unit acss_checker u_acss_checker (.*);
